[src/c_subset_lexer_defines.svh]
// assertion helpers shared by the lexer rtl
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// same-cycle implication, muted during reset
`define CSLEX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted during reset
`define CSLEX_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cslex_pkg.sv]
package cslex_pkg;

   // default cap on the run counter
   localparam int DEF_MAX_LEN = 255;

   // result queue
   localparam int QUEUE_DEPTH = 4;

   localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

   // scanner modes
   localparam logic [3:0] MODE_IDLE  = 4'd0;
   localparam logic [3:0] MODE_IDENT = 4'd1;
   localparam logic [3:0] MODE_NUM   = 4'd2;
   localparam logic [3:0] MODE_LT    = 4'd3;
   localparam logic [3:0] MODE_GT    = 4'd4;
   localparam logic [3:0] MODE_BANG  = 4'd5;
   localparam logic [3:0] MODE_EQ    = 4'd6;
   localparam logic [3:0] MODE_STR   = 4'd7;
   localparam logic [3:0] MODE_CH1   = 4'd8;
   localparam logic [3:0] MODE_CH2   = 4'd9;

   // token kinds
   localparam logic [5:0] TK_NONE   = 6'd0;
   localparam logic [5:0] TK_NUMBER = 6'd18;
   localparam logic [5:0] TK_CHAR   = 6'd19;
   localparam logic [5:0] TK_IDENT  = 6'd20;
   localparam logic [5:0] TK_STRING = 6'd21;
   localparam logic [5:0] TK_PLUS   = 6'd22;
   localparam logic [5:0] TK_MINUS  = 6'd23;
   localparam logic [5:0] TK_STAR   = 6'd24;
   localparam logic [5:0] TK_SLASH  = 6'd25;
   localparam logic [5:0] TK_LPAR   = 6'd26;
   localparam logic [5:0] TK_RPAR   = 6'd27;
   localparam logic [5:0] TK_COMMA  = 6'd28;
   localparam logic [5:0] TK_SEMI   = 6'd29;
   localparam logic [5:0] TK_ASSIGN = 6'd32;
   localparam logic [5:0] TK_LT     = 6'd33;
   localparam logic [5:0] TK_LE     = 6'd34;
   localparam logic [5:0] TK_GT     = 6'd35;
   localparam logic [5:0] TK_GE     = 6'd36;
   localparam logic [5:0] TK_NE     = 6'd37;
   localparam logic [5:0] TK_EQ     = 6'd38;
   localparam logic [5:0] TK_LBRK   = 6'd40;
   localparam logic [5:0] TK_RBRK   = 6'd41;
   localparam logic [5:0] TK_LBRACE = 6'd42;
   localparam logic [5:0] TK_RBRACE = 6'd43;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BANG     = 3'd1;
   localparam logic [2:0] ERR_STR_CHAR = 3'd2;
   localparam logic [2:0] ERR_CH_LONG  = 3'd3;
   localparam logic [2:0] ERR_CH_BAD   = 3'd4;
   localparam logic [2:0] ERR_UNEXP    = 3'd5;
   localparam logic [2:0] ERR_OVERFLOW = 3'd6;

   // special bytes
   localparam logic [7:0] CH_DQUOTE = 8'd34;
   localparam logic [7:0] CH_SQUOTE = 8'd39;
   localparam logic [7:0] CH_TILDE  = 8'd126;

   // reserved words, right-justified text, kinds 1 to 12 in order
   localparam int KW_COUNT = 12;
   localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
      56'("const"), 56'("int"), 56'("char"), 56'("void"), 56'("main"), 56'("if"),
      56'("else"), 56'("while"), 56'("for"), 56'("scanf"), 56'("printf"),
      56'("return")
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
   };

   // one result as queued
   typedef struct packed {
      logic        last;
      logic        done;
      logic [15:0] line;
      logic [7:0]  length;
      logic [30:0] value;
      logic [2:0]  err;
      logic [5:0]  kind;
   } rsp_type;

   function automatic rsp_type mk_res(input logic [5:0] kind, input logic [2:0] err,
                                      input logic [30:0] value, input logic [7:0] length,
                                      input logic [15:0] line, input logic done);
      rsp_type r;
      r.last   = 1'b0;
      r.done   = done;
      r.line   = line;
      r.length = length;
      r.value  = value;
      r.err    = err;
      r.kind   = kind;
      return r;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   // bytes allowed inside a char literal
   function automatic logic char_ok(input logic [7:0] c);
      return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F} || is_letter(c) || is_digit(c);
   endfunction

   // bytes allowed inside a string body
   function automatic logic str_ok(input logic [7:0] c);
      return c inside {8'h20, 8'h21, [8'h23:CH_TILDE]};
   endfunction

   // single-byte operators, TK_NONE when not one
   function automatic logic [5:0] op_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h2B:   k = TK_PLUS;
         8'h2D:   k = TK_MINUS;
         8'h2A:   k = TK_STAR;
         8'h2F:   k = TK_SLASH;
         8'h28:   k = TK_LPAR;
         8'h29:   k = TK_RPAR;
         8'h2C:   k = TK_COMMA;
         8'h3B:   k = TK_SEMI;
         8'h5B:   k = TK_LBRK;
         8'h5D:   k = TK_RBRK;
         8'h7B:   k = TK_LBRACE;
         8'h7D:   k = TK_RBRACE;
         default: k = TK_NONE;
      endcase
      return k;
   endfunction

   // reserved word lookup on the stored lower-case prefix
   function automatic logic [5:0] kw_kind(input logic [6:0][7:0] pre, input logic [16:0] len);
      logic [55:0] w;
      logic [5:0]  k;
      w = '0;
      k = TK_IDENT;
      for (int j = 0; j < 7; j++) begin
         if (17'(j) < len) begin
            w = {w[47:0], pre[j]};
         end
      end
      for (int i = 0; i < KW_COUNT; i++) begin
         if (len == 17'(KW_LEN[i]) && w == KW_TEXT[i]) begin
            k = 6'(i + 1);
         end
      end
      return k;
   endfunction

   // acc * 10 + digit, held at VAL_MAX on overflow; returns {overflow, value}
   function automatic logic [31:0] num_step(input logic [30:0] acc, input logic [3:0] dig);
      logic [34:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 35'(dig);
      if (v > 35'(VAL_MAX)) begin
         return {1'b1, VAL_MAX};
      end
      return {1'b0, v[30:0]};
   endfunction

endpackage

[src/c_subset_lexer.sv]
// channel   dir  tdata                          tuser        tlast
// req_      in   [7:0] in_char                  end_of_input -
// rsp_      out  kind/err/value/length/line     is_done      last of item
//
// one source byte is taken per cycle while req_tready is high; the scanner state updates in the same cycle
// a byte gives zero, one or two results, queued in a four-entry result queue that
// drains one transfer per cycle while rsp_tready is high; req_tready drops while more than two are queued
// reset is synchronous: mode idle, line count one, queue empty; no clearing pass
// a stalled result side only holds off input once the queue is nearly full
`include "c_subset_lexer_defines.svh"

module c_subset_lexer import cslex_pkg::*; #(
   parameter int MAX_LEN = DEF_MAX_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] token_kind, [8:6] error_code, [39:9] token_value,
   // [47:40] token_length, [63:48] line_number
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] is_done
   output logic        rsp_tlast
);

   localparam int RunW = $clog2(MAX_LEN + 1);
   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   // scanner state
   logic [3:0]       mode_ff, mode_in;
   logic [RunW-1:0]  run_len_ff, run_len_in;
   logic [30:0]      acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic [15:0]      line_cnt_ff, line_cnt_in;
   logic [7:0]       lit_ff, lit_in;
   logic [6:0][7:0]  prefix_ff;

   // result queue
   rsp_type          queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   logic             accept, pop;
   logic [7:0]       c;
   logic             eoi;
   logic [16:0]      run_wide;
   logic [7:0]       len_out;
   logic [RunW-1:0]  run_bump;
   logic [5:0]       ident_kind;
   logic [31:0]      num_next;
   logic [7:0]       lower;
   logic             pre_we;
   logic [2:0]       pre_idx;
   logic             a_v, b_v, rescan;
   rsp_type          a_res, b_res, slot0, slot1, head;
   logic [1:0]       n_push;

   assign c      = req_tdata;
   assign eoi    = req_tuser;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // shared helpers for the current byte
   assign run_wide   = 17'(run_len_ff);
   assign len_out    = (run_wide > 17'd255) ? 8'hFF : run_wide[7:0];
   assign run_bump   = (run_len_ff < RunW'(MAX_LEN)) ? run_len_ff + 1'b1 : run_len_ff;
   assign ident_kind = kw_kind(prefix_ff, run_wide);
   assign num_next   = num_step(acc_ff, 4'(c - 8'h30));
   assign lower      = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;

   // next scanner state and up to two results for this byte
   always_comb begin
      mode_in     = mode_ff;
      run_len_in  = run_len_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      line_cnt_in = line_cnt_ff;
      lit_in      = lit_ff;
      pre_we      = 1'b0;
      pre_idx     = run_wide[2:0];
      a_v         = 1'b0;
      a_res       = '0;
      b_v         = 1'b0;
      b_res       = '0;
      rescan      = 1'b0;

      if (eoi) begin
         // flush the pending token, then report done
         a_v = 1'b1;
         case (mode_ff)
            MODE_IDENT: a_res = mk_res(ident_kind, ERR_NONE, '0, len_out, line_cnt_ff, 1'b0);
            MODE_NUM:   a_res = mk_res(TK_NUMBER, ovf_ff ? ERR_OVERFLOW : ERR_NONE, acc_ff,
                                       len_out, line_cnt_ff, 1'b0);
            MODE_LT:    a_res = mk_res(TK_LT, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
            MODE_GT:    a_res = mk_res(TK_GT, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
            MODE_EQ:    a_res = mk_res(TK_ASSIGN, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
            MODE_BANG:  a_res = mk_res(TK_NONE, ERR_BANG, '0, '0, line_cnt_ff, 1'b0);
            MODE_STR:   a_res = mk_res(TK_NONE, ERR_STR_CHAR, '0, '0, line_cnt_ff, 1'b0);
            MODE_CH1:   a_res = mk_res(TK_NONE, ERR_CH_BAD, '0, '0, line_cnt_ff, 1'b0);
            MODE_CH2:   a_res = mk_res(TK_NONE, ERR_CH_LONG, '0, '0, line_cnt_ff, 1'b0);
            default:    a_v = 1'b0;
         endcase
         mode_in = MODE_IDLE;
         b_v     = 1'b1;
         b_res   = mk_res(TK_NONE, ERR_NONE, '0, '0, line_cnt_ff, 1'b1);
      end else begin
         // continue or close the pending token
         case (mode_ff)
            MODE_IDENT: begin
               if (is_letter(c) || is_digit(c)) begin
                  pre_we     = (run_wide < 17'd7);
                  run_len_in = run_bump;
               end else begin
                  a_v    = 1'b1;
                  a_res  = mk_res(ident_kind, ERR_NONE, '0, len_out, line_cnt_ff, 1'b0);
                  rescan = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(c)) begin
                  if (!ovf_ff) begin
                     ovf_in = num_next[31];
                     acc_in = num_next[30:0];
                  end
                  run_len_in = run_bump;
               end else begin
                  a_v    = 1'b1;
                  a_res  = mk_res(TK_NUMBER, ovf_ff ? ERR_OVERFLOW : ERR_NONE, acc_ff,
                                  len_out, line_cnt_ff, 1'b0);
                  rescan = 1'b1;
               end
            end
            MODE_LT, MODE_GT, MODE_EQ, MODE_BANG: begin
               mode_in = MODE_IDLE;
               a_v     = 1'b1;
               if (c == 8'h3D) begin
                  case (mode_ff)
                     MODE_LT:   a_res = mk_res(TK_LE, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                     MODE_GT:   a_res = mk_res(TK_GE, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                     MODE_EQ:   a_res = mk_res(TK_EQ, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                     default:   a_res = mk_res(TK_NE, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                  endcase
               end else begin
                  rescan = 1'b1;
                  case (mode_ff)
                     MODE_LT:   a_res = mk_res(TK_LT, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                     MODE_GT:   a_res = mk_res(TK_GT, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                     MODE_EQ:   a_res = mk_res(TK_ASSIGN, ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
                     default:   a_res = mk_res(TK_NONE, ERR_BANG, '0, '0, line_cnt_ff, 1'b0);
                  endcase
               end
            end
            MODE_STR: begin
               if (c == CH_DQUOTE) begin
                  a_v     = 1'b1;
                  a_res   = mk_res(TK_STRING, ERR_NONE, '0, len_out, line_cnt_ff, 1'b0);
                  mode_in = MODE_IDLE;
               end else if (str_ok(c)) begin
                  run_len_in = run_bump;
               end else begin
                  a_v     = 1'b1;
                  a_res   = mk_res(TK_NONE, ERR_STR_CHAR, '0, '0, line_cnt_ff, 1'b0);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_CH1: begin
               if (char_ok(c)) begin
                  lit_in  = c;
                  mode_in = MODE_CH2;
               end else begin
                  a_v     = 1'b1;
                  a_res   = mk_res(TK_NONE, ERR_CH_BAD, '0, '0, line_cnt_ff, 1'b0);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_CH2: begin
               mode_in = MODE_IDLE;
               a_v     = 1'b1;
               if (c == CH_SQUOTE) begin
                  a_res = mk_res(TK_CHAR, ERR_NONE, {23'b0, lit_ff}, '0, line_cnt_ff, 1'b0);
               end else begin
                  a_res  = mk_res(TK_NONE, ERR_CH_LONG, '0, '0, line_cnt_ff, 1'b0);
                  rescan = 1'b1;
               end
            end
            default: rescan = 1'b1;
         endcase

         // scan the byte as the start of a new token
         if (rescan) begin
            mode_in = MODE_IDLE;
            if (c == 8'h20 || c == 8'h09) begin
               mode_in = MODE_IDLE;
            end else if (c == 8'h0A) begin
               line_cnt_in = (line_cnt_ff != 16'hFFFF) ? line_cnt_ff + 16'd1 : line_cnt_ff;
            end else if (is_letter(c)) begin
               mode_in    = MODE_IDENT;
               run_len_in = RunW'(1);
               pre_we     = 1'b1;
               pre_idx    = 3'd0;
            end else if (is_digit(c)) begin
               mode_in    = MODE_NUM;
               run_len_in = RunW'(1);
               acc_in     = {27'b0, 4'(c - 8'h30)};
               ovf_in     = 1'b0;
            end else if (c == 8'h3C) begin
               mode_in = MODE_LT;
            end else if (c == 8'h3E) begin
               mode_in = MODE_GT;
            end else if (c == 8'h21) begin
               mode_in = MODE_BANG;
            end else if (c == 8'h3D) begin
               mode_in = MODE_EQ;
            end else if (c == CH_DQUOTE) begin
               mode_in    = MODE_STR;
               run_len_in = '0;
            end else if (c == CH_SQUOTE) begin
               mode_in = MODE_CH1;
            end else begin
               b_v = 1'b1;
               if (op_kind(c) != TK_NONE) begin
                  b_res = mk_res(op_kind(c), ERR_NONE, '0, '0, line_cnt_ff, 1'b0);
               end else begin
                  b_res = mk_res(TK_NONE, ERR_UNEXP, '0, '0, line_cnt_ff, 1'b0);
               end
            end
         end
      end
   end

   // order results and mark the last one of the byte
   always_comb begin
      slot0  = a_v ? a_res : b_res;
      slot1  = b_res;
      n_push = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
      if (n_push == 2'd2) begin
         slot1.last = 1'b1;
      end else begin
         slot0.last = 1'b1;
      end
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(n_push) - CntW'(pop);
   end

   assign req_tready = (cnt_ff <= CntW'(QUEUE_DEPTH - 2));
   assign rsp_tvalid = (cnt_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tdata  = {head.line, head.length, head.value, head.err, head.kind};
   assign rsp_tuser  = head.done;
   assign rsp_tlast  = head.last;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         run_len_ff  <= '0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         line_cnt_ff <= 16'd1;
         lit_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         if (accept) begin
            mode_ff     <= mode_in;
            run_len_ff  <= run_len_in;
            acc_ff      <= acc_in;
            ovf_ff      <= ovf_in;
            line_cnt_ff <= line_cnt_in;
            lit_ff      <= lit_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // identifier prefix and queue payload, no reset
   always_ff @(posedge clock) begin
      if (accept && pre_we) begin
         prefix_ff[pre_idx] <= lower;
      end
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= slot1;
      end
   end

   `CSLEX_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, cnt_ff <= CntW'(QUEUE_DEPTH), "result queue overfilled")
   `CSLEX_ASSERT_NXT(a_eoi_queued, clock, reset, req_tvalid && req_tready && req_tuser, (mode_ff == MODE_IDLE) && (cnt_ff != '0), "end of input left scanner busy or queue empty")
   `CSLEX_ASSERT_IMP(a_done_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "done result not marked last")
   `CSLEX_ASSERT_IMP(a_line_nonzero, clock, reset, 1'b1, line_cnt_ff != 16'd0, "line counter reached zero")

endmodule
